// ===== hdl/snor_pkg.sv =====
// Shared types, constants and frame builders for the SPI NOR command sequencer.
// Used by the channel interfaces, the step logic and the top level.
package snor_pkg;

   // field widths
   localparam int CMD_W     = 3;
   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 24;
   localparam int STATUS_W  = 8;
   localparam int TIMEOUT_W = 8;
   localparam int OPCODE_W  = 8;
   localparam int BYTES_W   = 9;

   // flash geometry
   localparam int PAGE_BYTES   = 256;
   localparam int SECTOR_BYTES = 4096;
   localparam int HEADER_BYTES = 5;
   localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
   localparam int CHUNK_W      = $clog2(PAGE_BYTES + 1);

   // results per request and result counter width
   localparam int RESULTS = 3;
   localparam int CNT_W   = $clog2(RESULTS + 1);
   localparam int IDX_W   = $clog2(RESULTS);

   // SPI opcodes
   localparam logic [OPCODE_W-1:0] OP_POLL  = 8'h05;
   localparam logic [OPCODE_W-1:0] OP_WREN  = 8'h06;
   localparam logic [OPCODE_W-1:0] OP_READ  = 8'h13;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 8'h12;
   localparam logic [OPCODE_W-1:0] OP_ERASE = 8'h21;
   localparam logic [OPCODE_W-1:0] OP_ID    = 8'h9F;

   // frame sizes without a data phase
   localparam logic [BYTES_W-1:0] POLL_BYTES = 9'd2;
   localparam logic [BYTES_W-1:0] WREN_BYTES = 9'd1;
   localparam logic [BYTES_W-1:0] ID_BYTES   = 9'd4;

   // register reset values
   localparam logic [TIMEOUT_W-1:0] READY_TIMEOUT_RESET = 8'd100;
   localparam logic [TIMEOUT_W-1:0] ID_TIMEOUT_RESET    = 8'd20;

   // result kinds
   localparam logic RESULT_FRAME = 1'b0;
   localparam logic RESULT_DONE  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ    = 3'd0,
      CMD_WRITE   = 3'd1,
      CMD_ERASE   = 3'd2,
      CMD_READ_ID = 3'd3,
      CMD_STATUS  = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      OPER_READ  = 2'd0,
      OPER_WRITE = 2'd1,
      OPER_ERASE = 2'd2,
      OPER_ID    = 2'd3
   } operation_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PRE  = 2'd1,
      PH_POST = 2'd2
   } phase_type;

   typedef enum logic {
      CSR_READY_TIMEOUT = 1'b0,
      CSR_ID_TIMEOUT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [ADDR_W-1:0]   start_address;
      logic [LEN_W-1:0]    transfer_length;
      logic [STATUS_W-1:0] status_byte;
   } item_type;

   typedef struct packed {
      logic                  result_kind;
      logic [OPCODE_W-1:0]   frame_opcode;
      logic [ADDR_W-1:0]     frame_address;
      logic                  has_address;
      logic [BYTES_W-1:0]    frame_bytes;
      logic [LEN_W-1:0]      chunk_offset;
      logic                  timed_out;
      logic                  last;
   } result_type;

   typedef struct packed {
      phase_type             phase;
      operation_type         operation;
      logic [ADDR_W-1:0]     current_address;
      logic [LEN_W-1:0]      remaining;
      logic [LEN_W-1:0]      payload_offset;
      logic [CHUNK_W-1:0]    chunk_length;
      logic [TIMEOUT_W-1:0]  polls_left;
   } state_type;

   // build a frame descriptor
   function automatic result_type make_frame(input logic [OPCODE_W-1:0] opcode,
                                             input logic [ADDR_W-1:0]   address,
                                             input logic                has_address,
                                             input logic [BYTES_W-1:0]  frame_bytes,
                                             input logic [LEN_W-1:0]    offset);
      result_type r;
      r.result_kind   = RESULT_FRAME;
      r.frame_opcode  = opcode;
      r.frame_address = address;
      r.has_address   = has_address;
      r.frame_bytes   = frame_bytes;
      r.chunk_offset  = offset;
      r.timed_out     = 1'b0;
      r.last          = 1'b0;
      return r;
   endfunction

   // build a request completion
   function automatic result_type make_done(input logic timed_out);
      result_type r;
      r = '0;
      r.result_kind = RESULT_DONE;
      r.timed_out   = timed_out;
      return r;
   endfunction

   // a zero budget counts as one poll
   function automatic logic [TIMEOUT_W-1:0] poll_budget(input logic [TIMEOUT_W-1:0] t);
      return (t == '0) ? TIMEOUT_W'(1) : t;
   endfunction

endpackage

// ===== hdl/snor_req_if.sv =====
// Request channel of the SPI NOR command sequencer: valid/ready plus one request.
// Depends on snor_pkg for field widths.
interface snor_req_if;
   logic                           valid;
   logic                           ready;
   logic [snor_pkg::CMD_W-1:0]     command;
   logic [snor_pkg::ADDR_W-1:0]    start_address;
   logic [snor_pkg::LEN_W-1:0]     transfer_length;
   logic [snor_pkg::STATUS_W-1:0]  status_byte;

   modport source (output valid, command, start_address, transfer_length, status_byte,
                   input ready);
   modport sink (input valid, command, start_address, transfer_length, status_byte,
                 output ready);
endinterface

// ===== hdl/snor_rsp_if.sv =====
// Result channel of the SPI NOR command sequencer: frame descriptors and completions.
// Depends on snor_pkg for field widths.
interface snor_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [snor_pkg::OPCODE_W-1:0]  frame_opcode;
   logic [snor_pkg::ADDR_W-1:0]    frame_address;
   logic                           has_address;
   logic [snor_pkg::BYTES_W-1:0]   frame_bytes;
   logic [snor_pkg::LEN_W-1:0]     chunk_offset;
   logic                           timed_out;
   logic                           last;

   modport source (output valid, result_kind, frame_opcode, frame_address, has_address,
                   frame_bytes, chunk_offset, timed_out, last,
                   input ready);
   modport sink (input valid, result_kind, frame_opcode, frame_address, has_address,
                 frame_bytes, chunk_offset, timed_out, last,
                 output ready);
endinterface

// ===== hdl/snor_step.sv =====
// Combinational step of the sequencer: one registered request and the current
// state give the next state and up to three results. Depends on snor_pkg.
module snor_step (
   input  snor_pkg::state_type                               state,
   input  snor_pkg::item_type                                item,
   input  logic [snor_pkg::TIMEOUT_W-1:0]                    ready_timeout,
   input  logic [snor_pkg::TIMEOUT_W-1:0]                    id_timeout,
   output snor_pkg::state_type                               state_next,
   output snor_pkg::result_type [snor_pkg::RESULTS-1:0]      results,
   output logic [snor_pkg::CNT_W-1:0]                        count
);

   logic                                  active;
   logic [snor_pkg::TIMEOUT_W-1:0]        ready_budget;
   logic [snor_pkg::TIMEOUT_W-1:0]        id_budget;
   logic [snor_pkg::CHUNK_W-1:0]          page_space;
   logic [snor_pkg::CHUNK_W-1:0]          chunk;
   logic [snor_pkg::LEN_W-1:0]            remaining_dec;
   logic [snor_pkg::LEN_W-1:0]            remaining_post;
   logic [snor_pkg::TIMEOUT_W-1:0]        polls_dec;
   logic [snor_pkg::BYTES_W-1:0]          rw_bytes;
   logic [snor_pkg::OPCODE_W-1:0]         rw_opcode;
   snor_pkg::result_type                  poll_frame;
   snor_pkg::result_type [snor_pkg::RESULTS-1:0] res;
   logic [snor_pkg::CNT_W-1:0]            cnt;
   logic [snor_pkg::IDX_W-1:0]            last_idx;

   // shared arithmetic
   assign active       = (state.phase == snor_pkg::PH_PRE) || (state.phase == snor_pkg::PH_POST);
   assign ready_budget = snor_pkg::poll_budget(ready_timeout);
   assign id_budget    = snor_pkg::poll_budget(id_timeout);
   assign page_space   = snor_pkg::CHUNK_W'(snor_pkg::PAGE_BYTES)
                         - snor_pkg::CHUNK_W'(state.current_address[snor_pkg::PAGE_LOG-1:0]);
   assign remaining_dec  = state.remaining - snor_pkg::LEN_W'(1);
   assign remaining_post = state.remaining - snor_pkg::LEN_W'(state.chunk_length);
   assign polls_dec      = state.polls_left - snor_pkg::TIMEOUT_W'(1);
   assign rw_bytes       = snor_pkg::BYTES_W'(snor_pkg::HEADER_BYTES) + snor_pkg::BYTES_W'(chunk);
   assign rw_opcode      = (state.operation == snor_pkg::OPER_READ) ? snor_pkg::OP_READ
                                                                    : snor_pkg::OP_WRITE;
   assign poll_frame     = snor_pkg::make_frame(snor_pkg::OP_POLL, '0, 1'b0,
                                                snor_pkg::POLL_BYTES, '0);

   // chunk size: reads by whole pages, writes up to the page boundary
   always_comb begin
      if (state.operation == snor_pkg::OPER_READ) begin
         chunk = (state.remaining > snor_pkg::LEN_W'(snor_pkg::PAGE_BYTES))
                 ? snor_pkg::CHUNK_W'(snor_pkg::PAGE_BYTES)
                 : snor_pkg::CHUNK_W'(state.remaining);
      end else begin
         chunk = (snor_pkg::LEN_W'(page_space) < state.remaining)
                 ? page_space : snor_pkg::CHUNK_W'(state.remaining);
      end
   end

   // decode the request and build its results
   always_comb begin
      state_next = state;
      res        = '0;
      cnt        = '0;
      case (item.command)
         snor_pkg::CMD_READ, snor_pkg::CMD_WRITE, snor_pkg::CMD_ERASE,
         snor_pkg::CMD_READ_ID: begin
            if (!active) begin
               state_next.operation       = snor_pkg::operation_type'(item.command[1:0]);
               state_next.current_address = item.start_address;
               state_next.remaining       = item.transfer_length;
               state_next.payload_offset  = '0;
               state_next.chunk_length    = '0;
               cnt                        = snor_pkg::CNT_W'(1);
               if (item.command != snor_pkg::CMD_READ_ID && item.transfer_length == '0) begin
                  res[0]           = snor_pkg::make_done(1'b0);
                  state_next.phase = snor_pkg::PH_IDLE;
               end else begin
                  res[0]                = poll_frame;
                  state_next.phase      = snor_pkg::PH_PRE;
                  state_next.polls_left = (item.command == snor_pkg::CMD_READ_ID)
                                          ? id_budget : ready_budget;
               end
            end
         end
         snor_pkg::CMD_STATUS: begin
            if (active) begin
               if (item.status_byte[0]) begin
                  // device still busy: spend one poll
                  state_next.polls_left = polls_dec;
                  cnt                   = snor_pkg::CNT_W'(1);
                  if (polls_dec == '0) begin
                     res[0]           = snor_pkg::make_done(1'b1);
                     state_next.phase = snor_pkg::PH_IDLE;
                  end else begin
                     res[0] = poll_frame;
                  end
               end else if (state.phase == snor_pkg::PH_PRE) begin
                  // device ready: issue the chunk
                  case (state.operation)
                     snor_pkg::OPER_ID: begin
                        res[0] = snor_pkg::make_frame(snor_pkg::OP_ID, '0, 1'b0,
                                                      snor_pkg::ID_BYTES, '0);
                        res[1] = snor_pkg::make_done(1'b0);
                        cnt    = snor_pkg::CNT_W'(2);
                        state_next.phase = snor_pkg::PH_IDLE;
                     end
                     snor_pkg::OPER_ERASE: begin
                        res[0] = snor_pkg::make_frame(snor_pkg::OP_WREN, '0, 1'b0,
                                                      snor_pkg::WREN_BYTES, '0);
                        res[1] = snor_pkg::make_frame(snor_pkg::OP_ERASE, state.current_address,
                                    1'b1, snor_pkg::BYTES_W'(snor_pkg::HEADER_BYTES), '0);
                        cnt    = snor_pkg::CNT_W'(3);
                        state_next.current_address = state.current_address
                                                     + snor_pkg::ADDR_W'(snor_pkg::SECTOR_BYTES);
                        state_next.remaining = remaining_dec;
                        if (remaining_dec == '0) begin
                           res[2]           = snor_pkg::make_done(1'b0);
                           state_next.phase = snor_pkg::PH_IDLE;
                        end else begin
                           res[2]                = poll_frame;
                           state_next.polls_left = ready_budget;
                        end
                     end
                     default: begin
                        res[0] = snor_pkg::make_frame(snor_pkg::OP_WREN, '0, 1'b0,
                                                      snor_pkg::WREN_BYTES, '0);
                        res[1] = snor_pkg::make_frame(rw_opcode, state.current_address, 1'b1,
                                                      rw_bytes, state.payload_offset);
                        res[2] = poll_frame;
                        cnt    = snor_pkg::CNT_W'(3);
                        state_next.chunk_length = chunk;
                        state_next.polls_left   = ready_budget;
                        state_next.phase        = snor_pkg::PH_POST;
                     end
                  endcase
               end else begin
                  // chunk finished: advance, then complete or wait for the next one
                  state_next.current_address = state.current_address
                                               + snor_pkg::ADDR_W'(state.chunk_length);
                  state_next.payload_offset  = state.payload_offset
                                               + snor_pkg::LEN_W'(state.chunk_length);
                  state_next.remaining       = remaining_post;
                  cnt                        = snor_pkg::CNT_W'(1);
                  if (remaining_post == '0) begin
                     res[0]           = snor_pkg::make_done(1'b0);
                     state_next.phase = snor_pkg::PH_IDLE;
                  end else begin
                     res[0]                = poll_frame;
                     state_next.phase      = snor_pkg::PH_PRE;
                     state_next.polls_left = (state.operation == snor_pkg::OPER_ID)
                                             ? id_budget : ready_budget;
                  end
               end
            end
         end
         default: begin
            cnt = '0;
         end
      endcase
   end

   // mark the final result of this request
   assign last_idx = snor_pkg::IDX_W'(cnt - snor_pkg::CNT_W'(1));

   always_comb begin
      results = res;
      if (cnt != '0) begin
         results[last_idx].last = 1'b1;
      end
   end

   assign count = cnt;

endmodule

// ===== hdl/spi_nor_command_sequencer.sv =====
// Top level of the SPI NOR command sequencer (four-byte addressing).
// Depends on snor_pkg, snor_req_if, snor_rsp_if and snor_step.
//
// Usage:
//   req_chan carries requests (read, write, sector erase, read id) and the status
//   bytes that the flash returns. rsp_chan carries SPI frame descriptors and
//   request completions; last marks the final result of one request.
//   csr_write_en/csr_index/csr_write_data set the poll budgets (ready_timeout,
//   id_timeout); write them only while the sequencer is idle.
// Flow:
//   A request is taken into an input register; when the result buffer is free, its
//   results (none to three) go from the step logic into the result buffer. The
//   result buffer sends one result per cycle while rsp_chan.ready is high. The
//   next request is taken while the current results drain.
// Reset:
//   Synchronous, active high. Clears the sequencer to idle, empties both
//   registers and restores ready_timeout to 100 and id_timeout to 20.
// Stalls:
//   While rsp_chan.ready is low the current result holds; one more request may
//   wait in the input register, then req_chan.ready drops.
module spi_nor_command_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   snor_req_if.sink                          req_chan,
   snor_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic                              csr_index,
   input  logic [snor_pkg::TIMEOUT_W-1:0]    csr_write_data
);

   logic [snor_pkg::TIMEOUT_W-1:0]               ready_timeout_ff;
   logic [snor_pkg::TIMEOUT_W-1:0]               id_timeout_ff;
   logic                                         in_valid_ff;
   snor_pkg::item_type                           in_item_ff;
   snor_pkg::item_type                           in_item_in;
   snor_pkg::state_type                          state_ff;
   snor_pkg::state_type                          state_in;
   snor_pkg::result_type [snor_pkg::RESULTS-1:0] res_ff;
   snor_pkg::result_type [snor_pkg::RESULTS-1:0] res_in;
   logic [snor_pkg::CNT_W-1:0]                   res_cnt_ff;
   logic [snor_pkg::CNT_W-1:0]                   res_cnt_in;
   logic [snor_pkg::CNT_W-1:0]                   res_idx_ff;
   logic                                         buf_last;
   logic                                         buf_free;
   snor_pkg::result_type                         out_res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_timeout_ff <= snor_pkg::READY_TIMEOUT_RESET;
         id_timeout_ff    <= snor_pkg::ID_TIMEOUT_RESET;
      end else if (csr_write_en) begin
         case (snor_pkg::csr_index_type'(csr_index))
            snor_pkg::CSR_READY_TIMEOUT: ready_timeout_ff <= csr_write_data;
            snor_pkg::CSR_ID_TIMEOUT:    id_timeout_ff    <= csr_write_data;
            default:                     ready_timeout_ff <= ready_timeout_ff;
         endcase
      end
   end

   // gather the request payload
   always_comb begin
      in_item_in.command         = req_chan.command;
      in_item_in.start_address   = req_chan.start_address;
      in_item_in.transfer_length = req_chan.transfer_length;
      in_item_in.status_byte     = req_chan.status_byte;
   end

   // step logic between input register and result buffer
   snor_step u_step (
      .state         (state_ff),
      .item          (in_item_ff),
      .ready_timeout (ready_timeout_ff),
      .id_timeout    (id_timeout_ff),
      .state_next    (state_in),
      .results       (res_in),
      .count         (res_cnt_in)
   );

   // buffer frees when empty or when its final result is taken
   assign buf_last  = (res_idx_ff == res_cnt_ff - snor_pkg::CNT_W'(1));
   assign buf_free  = (res_cnt_ff == '0) || (rsp_chan.ready && buf_last);
   assign req_chan.ready = !in_valid_ff || buf_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff <= in_item_in;
      end
   end

   // sequencer state and result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         res_cnt_ff <= '0;
         res_idx_ff <= '0;
      end else if (buf_free) begin
         res_idx_ff <= '0;
         if (in_valid_ff) begin
            state_ff   <= state_in;
            res_cnt_ff <= res_cnt_in;
         end else begin
            res_cnt_ff <= '0;
         end
      end else if (rsp_chan.ready) begin
         res_idx_ff <= res_idx_ff + snor_pkg::CNT_W'(1);
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      if (buf_free && in_valid_ff) begin
         res_ff <= res_in;
      end
   end

   // drive the result channel
   assign out_res = res_ff[res_idx_ff[snor_pkg::IDX_W-1:0]];

   assign rsp_chan.valid         = (res_cnt_ff != '0);
   assign rsp_chan.result_kind   = out_res.result_kind;
   assign rsp_chan.frame_opcode  = out_res.frame_opcode;
   assign rsp_chan.frame_address = out_res.frame_address;
   assign rsp_chan.has_address   = out_res.has_address;
   assign rsp_chan.frame_bytes   = out_res.frame_bytes;
   assign rsp_chan.chunk_offset  = out_res.chunk_offset;
   assign rsp_chan.timed_out     = out_res.timed_out;
   assign rsp_chan.last          = out_res.last;

   // read pointer stays inside the filled part of the buffer
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (res_idx_ff < res_cnt_ff))
      else $error("result index beyond buffered count");

   // last flags exactly the final buffered result
   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last == buf_last))
      else $error("last flag out of place");

   // a waiting sequencer always has a poll left
   a_polls_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != snor_pkg::PH_IDLE) |-> (state_ff.polls_left != '0))
      else $error("active wait with empty poll budget");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !in_valid_ff))
      else $error("result or request survived reset");

endmodule
